FILE: sv/htx_pkg.sv
// ----------------------------------------------------------------------------
// HDLC transmit framer package
// Word types, item kinds, constants and the CRC helpers shared by the framer.
// ----------------------------------------------------------------------------
`default_nettype none

package htx_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EOF   = 2'd1,
        KIND_OPEN  = 2'd2,
        KIND_CLOSE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } src_word_t;

    typedef struct packed {
        logic line_bit;
        logic last;
    } line_word_t;

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [7:0]  FLAG_OCTET = 8'h7E;
    localparam logic [2:0]  ONES_LIMIT = 3'd5;
    localparam logic [4:0]  OCTET_BITS = 5'd8;
    localparam logic [4:0]  FCS_BITS   = 5'd16;

    // One bit of the CRC-16 shift register, first sent bit first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic b);
        logic fb;
        fb = crc[15] ^ b;
        crc_step = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    endfunction

    function automatic logic [15:0] reverse16(input logic [15:0] v);
        for (int i = 0; i < 16; i++)
        begin
            reverse16[i] = v[15 - i];
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/htx_in_buf.sv
// ----------------------------------------------------------------------------
// HDLC transmit input buffer
// One-word register that holds an accepted item until the bit generator
// takes it, so the source side sees no gap between items.
// ----------------------------------------------------------------------------
`default_nettype none

module htx_in_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_ready,
    input  wire htx_pkg::src_word_t src_word,
    output logic                   load_valid,
    output htx_pkg::src_word_t     load_word,
    input  wire logic              load_take
);

    logic               valid_reg;
    logic               valid_next;
    htx_pkg::src_word_t word_reg;

    assign src_ready  = !valid_reg || load_take;
    assign load_valid = valid_reg;
    assign load_word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_take)
        begin
            valid_next = 1'b0;
        end
        if (src_valid && src_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
        begin
            word_reg <= src_word;
        end
    end

endmodule

`default_nettype wire

FILE: sv/htx_bitgen.sv
// ----------------------------------------------------------------------------
// HDLC transmit bit generator
// Shifts out source bits with CRC update, zero stuffing and NRZI coding,
// stalls with line_ready and registers each line bit on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module htx_bitgen (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load_valid,
    input  wire htx_pkg::src_word_t load_word,
    output logic                    load_take,
    output logic                    line_valid,
    input  wire logic               line_ready,
    output htx_pkg::line_word_t     line_word
);

    logic                busy_reg,     busy_next;
    logic                flag_reg,     flag_next;
    logic                crc_en_reg,   crc_en_next;
    logic                pending_reg,  pending_next;
    logic [4:0]          cnt_reg,      cnt_next;
    logic [15:0]         shift_reg,    shift_next;
    logic [15:0]         crc_reg,      crc_next;
    logic [2:0]          ones_reg,     ones_next;
    logic                level_reg,    level_next;
    logic                between_reg,  between_next;
    logic                out_valid_reg, out_valid_next;
    htx_pkg::line_word_t out_word_reg, out_word_next;

    logic                emit;
    logic                emit_last;
    logic                src_bit;
    logic [15:0]         fcs;

    assign line_valid = out_valid_reg;
    assign line_word  = out_word_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        flag_next      = flag_reg;
        crc_en_next    = crc_en_reg;
        pending_next   = pending_reg;
        cnt_next       = cnt_reg;
        shift_next     = shift_reg;
        crc_next       = crc_reg;
        ones_next      = ones_reg;
        level_next     = level_reg;
        between_next   = between_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        emit_last      = 1'b0;
        src_bit        = shift_reg[0];
        fcs            = 16'h0000;

        emit = busy_reg && (!out_valid_reg || line_ready);

        if (emit)
        begin
            if (pending_reg)
            begin
                // Stuffed zero after five ones.
                level_next   = !level_reg;
                ones_next    = 3'd0;
                pending_next = 1'b0;
                emit_last    = (cnt_reg == 5'd0);
            end
            else
            begin
                shift_next = {1'b0, shift_reg[15:1]};
                cnt_next   = cnt_reg - 5'd1;
                level_next = level_reg ^ !src_bit;
                if (flag_reg)
                begin
                    emit_last = (cnt_reg == 5'd1);
                end
                else
                begin
                    if (crc_en_reg)
                    begin
                        crc_next = htx_pkg::crc_step(crc_reg, src_bit);
                    end
                    if (src_bit)
                    begin
                        if (ones_reg + 3'd1 == htx_pkg::ONES_LIMIT)
                        begin
                            pending_next = 1'b1;
                            ones_next    = 3'd0;
                        end
                        else
                        begin
                            ones_next = ones_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        ones_next = 3'd0;
                    end
                    emit_last = (cnt_reg == 5'd1) && !pending_next;
                end
            end
            out_valid_next         = 1'b1;
            out_word_next.line_bit = level_next;
            out_word_next.last     = emit_last;
            if (emit_last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (out_valid_reg && line_ready)
        begin
            out_valid_next = 1'b0;
        end

        load_take = load_valid && (!busy_reg || (emit && emit_last));

        // Frame state changes of a new item apply after the previous item's
        // final bit has been coded.
        if (load_take)
        begin
            busy_next    = 1'b1;
            pending_next = 1'b0;
            case (htx_pkg::kind_t'(load_word.kind))
                htx_pkg::KIND_DATA:
                begin
                    if (between_next)
                    begin
                        level_next   = 1'b1;
                        crc_next     = htx_pkg::CRC_PRESET;
                        ones_next    = 3'd0;
                        between_next = 1'b0;
                    end
                    flag_next   = 1'b0;
                    crc_en_next = 1'b1;
                    cnt_next    = htx_pkg::OCTET_BITS;
                    shift_next  = {8'h00, load_word.data_byte};
                end
                htx_pkg::KIND_EOF:
                begin
                    if (between_next)
                    begin
                        level_next   = 1'b1;
                        crc_next     = htx_pkg::CRC_PRESET;
                        ones_next    = 3'd0;
                        between_next = 1'b0;
                    end
                    fcs         = ~crc_next;
                    flag_next   = 1'b0;
                    crc_en_next = 1'b0;
                    cnt_next    = htx_pkg::FCS_BITS;
                    shift_next  = htx_pkg::reverse16(fcs);
                    crc_next    = htx_pkg::CRC_PRESET;
                end
                htx_pkg::KIND_OPEN:
                begin
                    level_next   = 1'b1;
                    crc_next     = htx_pkg::CRC_PRESET;
                    ones_next    = 3'd0;
                    between_next = 1'b0;
                    flag_next    = 1'b1;
                    crc_en_next  = 1'b0;
                    cnt_next     = htx_pkg::OCTET_BITS;
                    shift_next   = {8'h00, htx_pkg::FLAG_OCTET};
                end
                default:
                begin
                    crc_next     = htx_pkg::CRC_PRESET;
                    ones_next    = 3'd0;
                    between_next = 1'b1;
                    flag_next    = 1'b1;
                    crc_en_next  = 1'b0;
                    cnt_next     = htx_pkg::OCTET_BITS;
                    shift_next   = {8'h00, htx_pkg::FLAG_OCTET};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            flag_reg      <= 1'b0;
            crc_en_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            cnt_reg       <= 5'd0;
            crc_reg       <= htx_pkg::CRC_PRESET;
            ones_reg      <= 3'd0;
            level_reg     <= 1'b1;
            between_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            flag_reg      <= flag_next;
            crc_en_reg    <= crc_en_next;
            pending_reg   <= pending_next;
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            ones_reg      <= ones_next;
            level_reg     <= level_next;
            between_reg   <= between_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

FILE: sv/hdlc_tx_framer_nrzi.sv
// ----------------------------------------------------------------------------
// HDLC transmit framer with NRZI line coding
// Turns data, end-of-frame and flag words into a stuffed, NRZI coded
// line bit stream with a CRC-16 frame check sequence.
// ----------------------------------------------------------------------------
// Usage:
// The src channel takes one word per item: a kind (data, end of frame,
// opening flag, closing flag) and a data byte. The line channel delivers
// one NRZI line bit per word, with last set on the final bit of an item.
// A data byte gives 8 to 10 line words, an end of frame 16 to 20, a flag 8.
// When the generator is free, the first line bit of an item passes through
// the input register and the generator state before the line register.
// The single bit generator gives one line bit per cycle while
// line_ready is high; a stall on the line side pauses it.
// A one-word input register lets the next item be taken while the current
// one is still being sent, so consecutive items follow without a gap.
// Reset puts the line level at 1, presets the CRC, clears the stuffing
// count and marks the framer as between frames.
// When line_ready is low the registered line word holds and bit
// generation pauses; src_ready drops once the input register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_tx_framer_nrzi (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_ready,
    input  wire htx_pkg::src_word_t src_word,
    output logic                    line_valid,
    input  wire logic               line_ready,
    output htx_pkg::line_word_t     line_word
);

    logic               load_valid;
    logic               load_take;
    htx_pkg::src_word_t load_word;

    htx_in_buf u_in_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_word   (src_word),
        .load_valid (load_valid),
        .load_word  (load_word),
        .load_take  (load_take)
    );

    htx_bitgen u_bitgen (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_word  (load_word),
        .load_take  (load_take),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_word  (line_word)
    );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// HDLC transmit framer testbench
// Sends data, end-of-frame and flag words into the framer and checks every
// NRZI line bit against a bit-level model of stuffing, CRC and line coding.
// The model is kept in a scoreboard class; random idling on both sides, a
// long line stall and a full drain exercise the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    // Keeps the framer's state and the queue of line words still due.
    class line_scoreboard;

        htx_pkg::line_word_t pending[$];
        logic [15:0]         fcs_reg;
        logic [2:0]          ones_count;
        logic                level;
        logic                idle;
        int                  errors;
        int                  bits_checked;

        function new();
            fcs_reg      = htx_pkg::CRC_PRESET;
            ones_count   = 3'd0;
            level        = 1'b1;
            idle         = 1'b1;
            errors       = 0;
            bits_checked = 0;
        endfunction

        function void put_level(logic b);
            htx_pkg::line_word_t lw;
            if (!b)
                level = ~level;
            lw.line_bit = level;
            lw.last     = 1'b0;
            pending.push_back(lw);
        endfunction

        function void put_stuffed(logic b);
            put_level(b);
            if (b)
            begin
                ones_count = ones_count + 3'd1;
                if (ones_count >= htx_pkg::ONES_LIMIT)
                begin
                    put_level(1'b0);
                    ones_count = 3'd0;
                end
            end
            else
            begin
                ones_count = 3'd0;
            end
        endfunction

        function void shift_fcs(logic b);
            logic fb;
            fb      = fcs_reg[15] ^ b;
            fcs_reg = {fcs_reg[14:0], 1'b0};
            if (fb)
                fcs_reg = fcs_reg ^ htx_pkg::CRC_POLY;
        endfunction

        function void open_frame();
            level      = 1'b1;
            fcs_reg    = htx_pkg::CRC_PRESET;
            ones_count = 3'd0;
            idle       = 1'b0;
        endfunction

        function void put_flag();
            for (int i = 0; i < 8; i++)
                put_level(htx_pkg::FLAG_OCTET[i]);
        endfunction

        // Works out the line words that one accepted source word produces.
        function void note_item(htx_pkg::src_word_t w);
            logic [15:0] fcs;
            case (htx_pkg::kind_t'(w.kind))
                htx_pkg::KIND_DATA:
                begin
                    if (idle)
                        open_frame();
                    for (int i = 0; i < 8; i++)
                    begin
                        shift_fcs(w.data_byte[i]);
                        put_stuffed(w.data_byte[i]);
                    end
                end
                htx_pkg::KIND_EOF:
                begin
                    if (idle)
                        open_frame();
                    fcs = ~fcs_reg;
                    for (int i = 15; i >= 0; i--)
                        put_stuffed(fcs[i]);
                    fcs_reg = htx_pkg::CRC_PRESET;
                end
                htx_pkg::KIND_OPEN:
                begin
                    open_frame();
                    put_flag();
                end
                default:
                begin
                    put_flag();
                    fcs_reg    = htx_pkg::CRC_PRESET;
                    ones_count = 3'd0;
                    idle       = 1'b1;
                end
            endcase
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_bit(htx_pkg::line_word_t got);
            htx_pkg::line_word_t want;
            if (pending.size() == 0)
            begin
                $error("line word %0b/%0b arrived with nothing due",
                       got.line_bit, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            bits_checked++;
            if (got.line_bit !== want.line_bit)
            begin
                $error("line_bit: expected %0b, got %0b", want.line_bit, got.line_bit);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction

    endclass

    logic                clk;
    logic                rst_n;
    logic                src_valid;
    logic                src_ready;
    htx_pkg::src_word_t  src_word;
    logic                line_valid;
    logic                line_ready;
    htx_pkg::line_word_t line_word;

    line_scoreboard sb;
    logic           no_idle;
    int             kind_seen[4];
    int             random_sent;
    int             rx_cycle;

    hdlc_tx_framer_nrzi i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_word   (src_word),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_word  (line_word)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Line side: checks accepted words and drives ready, with one long stall.
    initial
    begin
        line_ready = 1'b0;
        rx_cycle   = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (line_valid && line_ready)
                sb.check_bit(line_word);
            if (rx_cycle >= 1200 && rx_cycle < 1600)
                line_ready <= 1'b0;
            else if (no_idle)
                line_ready <= 1'b1;
            else
                line_ready <= ($urandom_range(99) >= 38);
            rx_cycle++;
            @(posedge clk);
        end
    end

    task automatic send_word(input logic [1:0] kind, input logic [7:0] octet);
        htx_pkg::src_word_t w;
        w.kind      = kind;
        w.data_byte = octet;
        while (!no_idle && $urandom_range(99) < 38)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= w;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        sb.note_item(w);
        kind_seen[kind]++;
    endtask

    // Lowers valid and waits until every due line word has come out.
    task automatic drain_line();
        src_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    function automatic logic [7:0] pick_octet();
        case ($urandom_range(7))
            0:       return 8'hFF;
            1:       return 8'h00;
            2:       return htx_pkg::FLAG_OCTET;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_frames();
        int nbytes;
        while (random_sent < 300)
        begin
            if (random_sent >= 150 && random_sent < 160)
            begin
                drain_line();
                random_sent = 160;
            end
            no_idle = (random_sent >= 200 && random_sent < 260);
            if ($urandom_range(99) < 80)
            begin
                // Well-formed frame; now and then the opening flag is left out.
                if ($urandom_range(9) != 0)
                    send_word(htx_pkg::KIND_OPEN, 8'($urandom_range(255)));
                nbytes = $urandom_range(1, 8);
                for (int i = 0; i < nbytes; i++)
                    send_word(htx_pkg::KIND_DATA, pick_octet());
                send_word(htx_pkg::KIND_EOF, 8'($urandom_range(255)));
                send_word(htx_pkg::KIND_CLOSE, 8'($urandom_range(255)));
                random_sent += nbytes + 3;
            end
            else
            begin
                send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
                random_sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        sb          = new;
        rst_n       = 1'b0;
        src_valid   = 1'b0;
        src_word    = '0;
        no_idle     = 1'b0;
        random_sent = 0;
        for (int k = 0; k < 4; k++)
            kind_seen[k] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Plain frame with extreme octets and a stuffed run of ones.
        send_word(htx_pkg::KIND_OPEN, 8'h00);
        send_word(htx_pkg::KIND_DATA, 8'h00);
        send_word(htx_pkg::KIND_DATA, 8'hFF);
        send_word(htx_pkg::KIND_DATA, htx_pkg::FLAG_OCTET);
        send_word(htx_pkg::KIND_DATA, 8'h1F);
        send_word(htx_pkg::KIND_EOF, 8'hFF);
        send_word(htx_pkg::KIND_CLOSE, 8'hFF);
        // Data while idle starts a frame; an opening flag abandons it.
        send_word(htx_pkg::KIND_DATA, 8'hA5);
        send_word(htx_pkg::KIND_DATA, 8'h3C);
        send_word(htx_pkg::KIND_OPEN, 8'hFF);
        send_word(htx_pkg::KIND_DATA, 8'h80);
        send_word(htx_pkg::KIND_DATA, 8'h01);
        send_word(htx_pkg::KIND_EOF, 8'h00);
        send_word(htx_pkg::KIND_EOF, 8'h55);
        send_word(htx_pkg::KIND_CLOSE, 8'h00);
        // End of frame on an empty frame, then back-to-back closing flags.
        send_word(htx_pkg::KIND_EOF, 8'hAA);
        send_word(htx_pkg::KIND_CLOSE, 8'h00);
        send_word(htx_pkg::KIND_CLOSE, 8'hFF);
        send_word(htx_pkg::KIND_DATA, 8'hFF);
        send_word(htx_pkg::KIND_DATA, 8'hFF);
        send_word(htx_pkg::KIND_DATA, 8'hFF);
        send_word(htx_pkg::KIND_EOF, 8'h00);
        send_word(htx_pkg::KIND_CLOSE, 8'h00);
        drain_line();

        send_random_frames();
        drain_line();
        repeat (30) @(posedge clk);

        if (sb.pending.size() != 0)
        begin
            $error("%0d line words never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Sent %0d data, %0d end-of-frame, %0d opening and %0d closing flag words.",
                 kind_seen[htx_pkg::KIND_DATA], kind_seen[htx_pkg::KIND_EOF],
                 kind_seen[htx_pkg::KIND_OPEN], kind_seen[htx_pkg::KIND_CLOSE]);
        $display("Checked %0d line bits with %0d mismatches.", sb.bits_checked, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out waiting for the framer.");
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
